[src/multi_waveform_sample_generator_assert.svh]
// Assertion macros for the waveform generator top level.
`ifndef MULTI_WAVEFORM_SAMPLE_GENERATOR_ASSERT_SVH
`define MULTI_WAVEFORM_SAMPLE_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MWSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MWSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/mwsg_pkg.sv]
// Package: widths, codes, sideband type and the quarter-wave cosine table.
package mwsg_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int PERIOD_WIDTH    = 24;
  localparam int IDX_WIDTH       = 32;
  localparam int FRAC_WIDTH      = 16;
  localparam int DIV_DEPTH       = IDX_WIDTH + FRAC_WIDTH;
  localparam int QTR             = (1 << SINE_TABLE_BITS) / 4;
  localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
  localparam int Q30_BITS        = 30;

  localparam longint PI_HALF_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint HALF_Q30    = ONE_Q30 / 2;

  localparam logic [2:0] SHAPE_NONE     = 3'd0;
  localparam logic [2:0] SHAPE_COSINE   = 3'd1;
  localparam logic [2:0] SHAPE_SQUARE   = 3'd2;
  localparam logic [2:0] SHAPE_TRIANGLE = 3'd3;
  localparam logic [2:0] SHAPE_SAWTOOTH = 3'd4;

  localparam logic [1:0] REG_SHAPE      = 2'd0;
  localparam logic [1:0] REG_AMPLITUDE  = 2'd1;
  localparam logic [1:0] REG_PERIOD     = 2'd2;
  localparam logic [1:0] REG_PHASE_STEP = 2'd3;

  typedef struct packed {
    logic                       vld;
    logic [SINE_TABLE_BITS-1:0] j;
  } side_t;

  typedef logic [14:0] cos_tab_t [0:QTR];

  // Restoring long division of a non-negative numerator by a small positive divisor.
  function automatic longint udiv_nonneg(longint num, longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r << 1) | ((num >>> b) & 64'sd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'sd1 << b);
      end
    end
    return q;
  endfunction

  // Evaluated at elaboration only; the Taylor series runs in Q30. Every
  // intermediate that gets scaled down is non-negative, so the shifts match
  // truncating division.
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t tab;
    longint   th;
    longint   x2;
    longint   t;
    longint   d;
    int       n;
    for (int m = 0; m <= QTR; m++) begin
      th = (PI_HALF_Q30 * longint'(m)) >>> QTR_BITS;
      x2 = (th * th) >>> Q30_BITS;
      t  = ONE_Q30;
      for (n = 18; n >= 2; n -= 2) begin
        d = longint'(n * (n - 1));
        t = ONE_Q30 - udiv_nonneg((x2 * t) >>> Q30_BITS, d);
      end
      if (t < 0) t = 0;
      tab[m] = 15'((64'sd32767 * t + HALF_Q30) >>> Q30_BITS);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

[src/multi_waveform_sample_generator.sv]
// Top level of the waveform sample generator.
// Usage: each input item carries a 32-bit sample index; each output item is
// one signed Q1.15 sample of the configured shape scaled by the amplitude.
// Both channels use valid/stall; an item moves on an edge where valid is high
// and stall is low. Configuration is a plain write port (shape, amplitude,
// period, cosine phase step); the user must write it only while the block is
// idle; the block itself does not enforce this. From acceptance to output
// valid, an item passes the phase-multiply register, one-bit-per-stage
// division (index modulo period, then fraction), table/operand, multiply
// and rounding stages. It takes one item per cycle unless the output stalls.
// When the receiver stalls a valid output, the whole pipeline freezes and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
// Synchronous reset clears all valid bits and loads the register defaults:
// shape none, amplitude 0, period 1000, phase step 0.
module multi_waveform_sample_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_sample_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  `include "multi_waveform_sample_generator_assert.svh"

  localparam int PW = mwsg_pkg::PERIOD_WIDTH;
  localparam int TB = mwsg_pkg::SINE_TABLE_BITS;
  localparam int FW = mwsg_pkg::FRAC_WIDTH;

  logic [2:0]    shape_r;
  logic [14:0]   amp_r;
  logic [PW-1:0] period_r;
  logic [31:0]   step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r  <= mwsg_pkg::SHAPE_NONE;
      amp_r    <= '0;
      period_r <= PW'(1000);
      step_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mwsg_pkg::REG_SHAPE:      shape_r  <= cfg_wdata[2:0];
        mwsg_pkg::REG_AMPLITUDE:  amp_r    <= cfg_wdata[14:0];
        mwsg_pkg::REG_PERIOD:     period_r <= cfg_wdata[PW-1:0];
        mwsg_pkg::REG_PHASE_STEP: step_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 1: register the index and the low word of the phase product.
  logic                   v1_r;
  logic [31:0]            idx1_r;
  logic [31:0]            phase_nxt;
  logic [31:0]            phase1_r;
  assign phase_nxt = 32'(in_sample_index * step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r   <= in_sample_index;
      phase1_r <= phase_nxt;
    end
  end

  mwsg_pkg::side_t side1;
  mwsg_pkg::side_t side_d;
  logic [FW-1:0]   frac_d;
  assign side1.vld = v1_r;
  assign side1.j   = phase1_r[31 -: TB];

  mwsg_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .period   (period_r),
    .in_idx   (idx1_r),
    .in_side  (side1),
    .out_frac (frac_d),
    .out_side (side_d)
  );

  // Stage A: cosine fold and table, or the piecewise-linear operand.
  logic [TB:0]          j_ext;
  logic [TB-2:0]        m;
  logic                 neg;
  logic [14:0]          mag;
  logic signed [19:0]   f4;
  logic signed [19:0]   tri_v;
  logic signed [19:0]   saw_v;
  logic signed [17:0]   op_nxt;
  logic                 sh16_nxt;
  logic                 va_r;
  logic signed [17:0]   op_r;
  logic                 sh16a_r;

  always_comb begin
    j_ext = {1'b0, side_d.j};
    if (j_ext <= (TB+1)'(mwsg_pkg::QTR)) begin
      m   = j_ext[TB-2:0];
      neg = 1'b0;
    end else if (j_ext <= (TB+1)'(2 * mwsg_pkg::QTR)) begin
      m   = (TB-1)'((TB+1)'(2 * mwsg_pkg::QTR) - j_ext);
      neg = 1'b1;
    end else if (j_ext < (TB+1)'(3 * mwsg_pkg::QTR)) begin
      m   = (TB-1)'(j_ext - (TB+1)'(2 * mwsg_pkg::QTR));
      neg = 1'b1;
    end else begin
      m   = (TB-1)'((TB+1)'(4 * mwsg_pkg::QTR) - j_ext);
      neg = 1'b0;
    end
    mag = mwsg_pkg::COS_TAB[m];

    f4    = $signed({2'b00, frac_d, 2'b00});
    tri_v = frac_d[FW-1] ? (20'sd196608 - f4) : (f4 - 20'sd65536);
    saw_v = $signed({3'b000, frac_d, 1'b0}) - 20'sd65536;

    op_nxt   = '0;
    sh16_nxt = 1'b1;
    case (shape_r)
      mwsg_pkg::SHAPE_COSINE: begin
        op_nxt   = neg ? -$signed({3'b000, mag}) : $signed({3'b000, mag});
        sh16_nxt = 1'b0;
      end
      mwsg_pkg::SHAPE_SQUARE: begin
        if (period_r != '0) op_nxt = frac_d[FW-1] ? -18'sd65536 : 18'sd65536;
      end
      mwsg_pkg::SHAPE_TRIANGLE: begin
        if (period_r != '0) op_nxt = tri_v[17:0];
      end
      mwsg_pkg::SHAPE_SAWTOOTH: begin
        if (period_r != '0) op_nxt = saw_v[17:0];
      end
      default: op_nxt = '0;
    endcase
  end

  // Stage B: amplitude product. Stage C: round and present.
  logic               vb_r;
  logic signed [33:0] prod_nxt;
  logic signed [33:0] prod_r;
  logic               sh16b_r;
  logic signed [33:0] sum;
  logic signed [33:0] rnd;
  logic signed [15:0] res_nxt;
  logic               out_valid_r;
  logic signed [15:0] out_value_r;

  assign prod_nxt = $signed({1'b0, amp_r}) * op_r;
  assign sum      = prod_r + (sh16b_r ? 34'sd32768 : 34'sd16384);
  assign rnd      = sh16b_r ? (sum >>> 16) : (sum >>> 15);
  assign res_nxt  = rnd[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      va_r        <= side_d.vld;
      vb_r        <= va_r;
      out_valid_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r        <= op_nxt;
      sh16a_r     <= sh16_nxt;
      prod_r      <= prod_nxt;
      sh16b_r     <= sh16a_r;
      out_value_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;

  `MWSG_ASSERT_NOW(a_op_range, va_r, (op_r <= 18'sd65536) && (op_r >= -18'sd65536), "operand out of range")
  `MWSG_ASSERT_NEXT(a_zero_op, vb_r && en && (prod_r == 34'sd0), out_sample_value == 16'sd0, "zero product gave nonzero sample")
  `MWSG_ASSERT_NEXT(a_freeze, out_valid_r && out_stall, $stable(prod_r) && $stable(vb_r), "pipeline moved during stall")

endmodule

[src/mwsg_div_pipe.sv]
// Bit-per-stage pipeline: index mod period, then (remainder << 16) / period.
module mwsg_div_pipe (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic [mwsg_pkg::PERIOD_WIDTH-1:0]  period,
  input  logic [mwsg_pkg::IDX_WIDTH-1:0]     in_idx,
  input  mwsg_pkg::side_t                    in_side,
  output logic [mwsg_pkg::FRAC_WIDTH-1:0]    out_frac,
  output mwsg_pkg::side_t                    out_side
);

  localparam int PW = mwsg_pkg::PERIOD_WIDTH;
  localparam int IW = mwsg_pkg::IDX_WIDTH;
  localparam int FW = mwsg_pkg::FRAC_WIDTH;
  localparam int DEPTH = mwsg_pkg::DIV_DEPTH;

  logic [PW-1:0]   rem_r  [DEPTH];
  logic [IW-1:0]   idx_r  [DEPTH];
  logic [FW-1:0]   quo_r  [DEPTH];
  mwsg_pkg::side_t side_r [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    logic [PW-1:0]   prev_rem;
    logic [IW-1:0]   prev_idx;
    logic [FW-1:0]   prev_quo;
    mwsg_pkg::side_t prev_side;
    logic            in_bit;
    logic [PW:0]     trial;
    logic [PW:0]     diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign prev_rem  = '0;
      assign prev_idx  = in_idx;
      assign prev_quo  = '0;
      assign prev_side = in_side;
    end else begin : g_rest
      assign prev_rem  = rem_r[k-1];
      assign prev_idx  = idx_r[k-1];
      assign prev_quo  = quo_r[k-1];
      assign prev_side = side_r[k-1];
    end

    // Modulo stages shift in index bits, fraction stages shift in zeros.
    if (k < IW) begin : g_mod
      assign in_bit = prev_idx[IW-1-k];
    end else begin : g_frac
      assign in_bit = 1'b0;
    end

    assign trial = {prev_rem, in_bit};
    assign ge    = (trial >= {1'b0, period});
    assign diff  = trial - {1'b0, period};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k].vld <= 1'b0;
      end else if (en) begin
        side_r[k] <= prev_side;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[PW-1:0] : trial[PW-1:0];
        idx_r[k] <= prev_idx;
        quo_r[k] <= {prev_quo[FW-2:0], ge};
      end
    end
  end

  assign out_frac = quo_r[DEPTH-1];
  assign out_side = side_r[DEPTH-1];

endmodule

[tb/tb_multi_waveform_sample_generator.sv]
// Testbench for the waveform sample generator: directed and random samples against a predictor.
module tb_multi_waveform_sample_generator;

  localparam int PIPE_LAT   = 52;
  localparam int IDLE_LIMIT = 5000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        in_sample_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_sample_value;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = mwsg_pkg::REG_SHAPE;
  logic [31:0]        cfg_wdata = '0;

  // Local copy of the register file.
  logic [2:0]  cur_shape = mwsg_pkg::SHAPE_NONE;
  logic [14:0] cur_amp = '0;
  logic [23:0] cur_period = 24'd1000;
  logic [31:0] cur_step = '0;

  longint             cos_lut [0:256];
  logic signed [15:0] pending_samples [$];
  int                 err_count = 0;
  int                 idle_cycles = 0;
  int                 burst_left = 0;
  int                 stall_cyc = 0;
  int                 stall_mode = 0;

  multi_waveform_sample_generator dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // 32767 * cos(pi/2 * m/256), Taylor series in Q30 with truncating divisions.
  function automatic longint quarter_wave(int m);
    longint th, x2, t;
    th = (64'sd1686629713 * longint'(m)) / 64'sd256;
    x2 = (th * th) / 64'sd1073741824;
    t  = 64'sd1073741824;
    for (int n = 18; n >= 2; n -= 2)
      t = 64'sd1073741824 - ((x2 * t) / 64'sd1073741824) / longint'(n * (n - 1));
    if (t < 0) t = 0;
    return (64'sd32767 * t + 64'sd536870912) / 64'sd1073741824;
  endfunction

  function automatic longint cos_value(int j);
    if (j <= 256) return cos_lut[j];
    if (j <= 512) return -cos_lut[512 - j];
    if (j < 768) return -cos_lut[j - 512];
    return cos_lut[1024 - j];
  endfunction

  function automatic logic signed [15:0] predict_sample(logic [31:0] idx);
    longint     a, v, f;
    logic [63:0] ph, s;
    a = longint'(cur_amp);
    v = 0;
    if (cur_shape == mwsg_pkg::SHAPE_COSINE) begin
      ph = 64'(idx) * 64'(cur_step);
      v = (a * cos_value(int'(ph[31:22])) + 64'sd16384) >>> 15;
    end else if ((cur_shape == mwsg_pkg::SHAPE_SQUARE ||
                  cur_shape == mwsg_pkg::SHAPE_TRIANGLE ||
                  cur_shape == mwsg_pkg::SHAPE_SAWTOOTH) && cur_period != 0) begin
      s = 64'(idx) % 64'(cur_period);
      f = longint'((s << 16) / 64'(cur_period));
      if (cur_shape == mwsg_pkg::SHAPE_SQUARE)
        v = (f < 32768) ? a : -a;
      else if (cur_shape == mwsg_pkg::SHAPE_TRIANGLE)
        v = (a * ((f < 32768) ? (4 * f - 65536) : (196608 - 4 * f)) + 64'sd32768) >>> 16;
      else
        v = (a * (2 * f - 65536) + 64'sd32768) >>> 16;
    end
    return v[15:0];
  endfunction

  task automatic send_sample(logic [31:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_sample_index <= idx;
    do @(posedge clk); while (in_stall);
    pending_samples.push_back(predict_sample(idx));
  endtask

  // Stops sending and waits until every expected sample has come out.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] shp, logic [31:0] amp, logic [31:0] per,
                           logic [31:0] stp);
    drain();
    cfg_we <= 1'b1; cfg_index <= mwsg_pkg::REG_SHAPE; cfg_wdata <= shp;
    @(posedge clk);
    cfg_index <= mwsg_pkg::REG_AMPLITUDE; cfg_wdata <= amp;
    @(posedge clk);
    cfg_index <= mwsg_pkg::REG_PERIOD; cfg_wdata <= per;
    @(posedge clk);
    cfg_index <= mwsg_pkg::REG_PHASE_STEP; cfg_wdata <= stp;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_shape  = shp[2:0];
    cur_amp    = amp[14:0];
    cur_period = per[23:0];
    cur_step   = stp;
  endtask

  function automatic logic [31:0] pick_index();
    logic [31:0] p, k;
    p = (cur_period == 0) ? 32'd1 : 32'(cur_period);
    k = $urandom_range(0, 4000);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 3000);
      2: return p * k + $urandom_range(0, 2) - 1;
      default: return p * k + p / 2 + $urandom_range(0, 2) - 1;
    endcase
  endfunction

  task automatic test_reset_defaults;
    send_sample(32'd0);
    send_sample(32'hFFFF_FFFF);
  endtask

  task automatic test_shape_extremes;
    configure(32'(mwsg_pkg::SHAPE_SQUARE), 32767, 1, 0);
    send_sample(32'd0); send_sample(32'hFFFF_FFFF);
    configure(32'(mwsg_pkg::SHAPE_TRIANGLE), 32767, 16777215, 0);
    send_sample(32'd0); send_sample(32'd8388607); send_sample(32'd8388608);
    send_sample(32'd16777214); send_sample(32'hFFFF_FFFF);
    configure(32'(mwsg_pkg::SHAPE_SAWTOOTH), 32767, 4, 0);
    send_sample(32'd0); send_sample(32'd1); send_sample(32'd2); send_sample(32'd3);
    configure(32'(mwsg_pkg::SHAPE_COSINE), 32767, 1000, 32'hFFFF_FFFF);
    send_sample(32'd0); send_sample(32'd1); send_sample(32'hFFFF_FFFF);
    configure(32'(mwsg_pkg::SHAPE_COSINE), 32767, 1000, 32'h0040_0000);
    send_sample(32'd256); send_sample(32'd512); send_sample(32'd768);
  endtask

  task automatic test_zero_period_and_masking;
    // Upper bits above each register's width are dropped; the period becomes zero.
    configure(32'hFFFF_FFFA, 32'hFFFF_FFFF, 32'hFF00_0000, 0);
    send_sample(32'd5); send_sample(32'hFFFF_FFFF);
    configure(32'(mwsg_pkg::SHAPE_SAWTOOTH), 0, 0, 0);
    send_sample(32'd77);
    configure(32'd7, 32767, 100, 32'h1234_5678);
    send_sample(32'd123);
  endtask

  task automatic test_random_phases;
    logic [31:0] amp, per, stp;
    for (int ph = 0; ph < 15; ph++) begin
      case ($urandom_range(0, 3))
        0: amp = 0;
        1: amp = 32767;
        default: amp = $urandom_range(0, 32767);
      endcase
      case ($urandom_range(0, 4))
        0: per = 1;
        1: per = 16777215;
        2: per = $urandom_range(1, 2000);
        default: per = $urandom;
      endcase
      stp = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom;
      configure($urandom_range(0, 7), amp, per, stp);
      for (int n = 0; n < 100; n++) begin
        if (ph == 7 && n == 50) drain();
        send_sample(pick_index());
      end
    end
  endtask

  always @(posedge clk) begin
    logic signed [15:0] exp_val;
    if (out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %0d", $time, out_sample_value);
        err_count++;
      end else begin
        exp_val = pending_samples.pop_front();
        if (out_sample_value !== exp_val) begin
          $display("%0t: sample_value mismatch, expected %0d, actual %0d",
                   $time, exp_val, out_sample_value);
          err_count++;
        end
      end
    end
  end

  // Receiver stall pattern, drawn from one of four modes.
  always @(posedge clk) begin
    stall_cyc++;
    if (stall_cyc % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ((stall_cyc % 16) < 5);
      default: out_stall <= $urandom_range(0, 1);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    for (int m = 0; m <= 256; m++) cos_lut[m] = quarter_wave(m);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_shape_extremes();
    test_zero_period_and_masking();
    test_random_phases();
    drain();
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
